/* rtl/pm_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pm_pkg
// Shared constants, types and control structs of the polynomial multiplier.
// ----------------------------------------------------------------------------
package pm_pkg;

  localparam int MAX_TERMS   = 32;
  localparam int COEFF_WIDTH = 32;
  localparam int PROD_TERMS  = 2 * MAX_TERMS - 1;

  localparam int IN_COEFF_W  = 32;
  localparam int OUT_COEFF_W = 32;
  localparam int OUT_DEG_W   = 6;

  localparam int IDX_W = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
  localparam int CNT_W = $clog2(MAX_TERMS + 1);
  localparam int DEG_W = $clog2(PROD_TERMS);

  typedef logic [COEFF_WIDTH-1:0] coeff_t;
  typedef logic [IDX_W-1:0]       idx_t;
  typedef logic [CNT_W-1:0]       cnt_t;
  typedef logic [DEG_W-1:0]       deg_t;

  // control token that travels alongside a multiply-accumulate operation
  typedef struct packed {
    logic valid;
    logic first;
    logic last;
    deg_t k;
  } mac_ctl_t;

  // completed convolution sum for one product degree
  typedef struct packed {
    logic   valid;
    deg_t   k;
    coeff_t sum;
  } mac_res_t;

endpackage

/* rtl/pm_in_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pm_in_if
// Coefficient load channel: valid/ready handshake with mode, coeff and last.
// ----------------------------------------------------------------------------
interface pm_in_if;
  logic               valid;
  logic               ready;
  logic               mode;
  logic signed [31:0] coeff;
  logic               last;

  modport source (output valid, output mode, output coeff, output last, input ready);
  modport sink   (input valid, input mode, input coeff, input last, output ready);
endinterface

/* rtl/pm_out_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pm_out_if
// Product coefficient channel: valid/ready handshake with result payload.
// ----------------------------------------------------------------------------
interface pm_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] prod_coeff;
  logic [5:0]         degree;
  logic               last_res;
  logic               is_zero;
  logic               overflow;

  modport source (output valid, output prod_coeff, output degree, output last_res,
                  output is_zero, output overflow, input ready);
  modport sink   (input valid, input prod_coeff, input degree, input last_res,
                  input is_zero, input overflow, output ready);
endinterface

/* rtl/pm_opstore.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pm_opstore
// Operand coefficient memories, one write port each, registered read data.
// ----------------------------------------------------------------------------
module pm_opstore
  import pm_pkg::*;
(
  input  logic   clk,
  input  logic   we_a,
  input  logic   we_b,
  input  idx_t   waddr,
  input  coeff_t wdata,
  input  idx_t   raddr_a,
  input  idx_t   raddr_b,
  output coeff_t rdata_a,
  output coeff_t rdata_b
);

  coeff_t mem_a [MAX_TERMS];
  coeff_t mem_b [MAX_TERMS];
  coeff_t rdata_a_r;
  coeff_t rdata_b_r;

  always_ff @(posedge clk) begin
    if (we_a) begin
      mem_a[waddr] <= wdata;
    end
    rdata_a_r <= mem_a[raddr_a];
  end

  always_ff @(posedge clk) begin
    if (we_b) begin
      mem_b[waddr] <= wdata;
    end
    rdata_b_r <= mem_b[raddr_b];
  end

  assign rdata_a = rdata_a_r;
  assign rdata_b = rdata_b_r;

endmodule

/* rtl/pm_mac.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pm_mac
// Shared multiply-accumulate pipeline: memory read, multiply, accumulate.
// ----------------------------------------------------------------------------
module pm_mac
  import pm_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  mac_ctl_t issue,
  input  coeff_t   op_a,
  input  coeff_t   op_b,
  output mac_res_t res,
  output logic     busy
);

  mac_ctl_t ctl1_r;
  mac_ctl_t ctl2_r;
  coeff_t   prod_r;
  coeff_t   acc_r;
  coeff_t   acc_nxt;
  logic     done_r;
  deg_t     done_k_r;

  // ctl1 lines up with the registered operand read data
  always_ff @(posedge clk) begin
    ctl1_r.first <= issue.first;
    ctl1_r.last  <= issue.last;
    ctl1_r.k     <= issue.k;
    ctl2_r.first <= ctl1_r.first;
    ctl2_r.last  <= ctl1_r.last;
    ctl2_r.k     <= ctl1_r.k;
    prod_r       <= coeff_t'(op_a * op_b);  // low bits only: wraps modulo 2^width
    done_k_r     <= ctl2_r.k;
    if (!rst_n) begin
      ctl1_r.valid <= 1'b0;
      ctl2_r.valid <= 1'b0;
      done_r       <= 1'b0;
    end else begin
      ctl1_r.valid <= issue.valid;
      ctl2_r.valid <= ctl1_r.valid;
      done_r       <= ctl2_r.valid & ctl2_r.last;
    end
  end

  always_comb begin
    acc_nxt = acc_r;
    if (ctl2_r.valid) begin
      acc_nxt = ctl2_r.first ? prod_r : coeff_t'(acc_r + prod_r);
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
  end

  assign res.valid = done_r;
  assign res.k     = done_k_r;
  assign res.sum   = acc_r;
  assign busy      = ctl1_r.valid | ctl2_r.valid | done_r;

endmodule

/* rtl/poly_multiply.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// poly_multiply
// Bounded-degree integer polynomial multiplier on one shared MAC unit.
// ----------------------------------------------------------------------------
// Usage: coefficients arrive on in_if in ascending degree order, mode 0 for
// operand one and mode 1 for operand two; last on operand two closes the load.
// The last coefficient of operand two starts the convolution; in_if.ready
// stays low until the last product coefficient has been placed in the output
// register.
// The convolution runs one multiply-accumulate per cycle on a single shared
// multiplier, n1 * n2 in all, where n1 and n2 are the operand term counts
// (at most 32 each). Results then leave on out_if from degree 0 up to the
// highest nonzero degree, each read from the product memory. A zero product
// leaves as one item with is_zero set. A stall on out_if holds the output
// register and the emit sequence; the block returns to loading as soon as
// the final result has been registered, even while it still waits to be
// taken.
// Reset (synchronous, rst_n low) clears the term counts, the overflow flag
// and the output valid; memory contents are not cleared.
// ----------------------------------------------------------------------------
module poly_multiply
  import pm_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  pm_in_if.sink    in_if,
  pm_out_if.source out_if
);

  localparam int W = DEG_W + 1;

  typedef enum logic [5:0] {
    ST_LOAD  = 6'b000001,
    ST_MAC   = 6'b000010,
    ST_DRAIN = 6'b000100,
    ST_RD    = 6'b001000,
    ST_LD    = 6'b010000,
    ST_ZERO  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  cnt_t fc_r, fc_nxt;
  cnt_t sc_r, sc_nxt;
  logic too_many_r, too_many_nxt;
  deg_t k_r, k_nxt;
  idx_t i_r, i_nxt;
  logic first_r, first_nxt;
  logic any_nz_r, any_nz_nxt;
  deg_t top_r, top_nxt;
  deg_t e_r, e_nxt;

  logic   out_valid_r, out_valid_nxt;
  coeff_t out_coeff_r;
  deg_t   out_deg_r;
  logic   out_last_r;
  logic   out_zero_r;
  logic   out_ovf_r;
  logic   out_load;
  logic   out_load_zero;

  logic   in_acc;
  coeff_t in_val;
  logic   we_a, we_b;
  idx_t   waddr;
  coeff_t rd_a, rd_b;
  idx_t   raddr_b;

  mac_ctl_t issue;
  mac_res_t res;
  logic     mac_busy;

  logic [W-1:0] kmax_w, iend_w, kn_w;
  idx_t         istart_n;
  logic         is_last;

  coeff_t prod_mem [PROD_TERMS];
  coeff_t prod_rd_r;
  logic   out_free;

  assign in_if.ready = (state_r == ST_LOAD);
  assign in_acc      = in_if.valid & in_if.ready;
  assign in_val      = coeff_t'(in_if.coeff);
  assign we_a        = in_acc & ~in_if.mode & (fc_r < cnt_t'(MAX_TERMS));
  assign we_b        = in_acc &  in_if.mode & (sc_r < cnt_t'(MAX_TERMS));
  assign waddr       = in_if.mode ? idx_t'(sc_r) : idx_t'(fc_r);

  // index bounds of the convolution sum for degree k
  assign kmax_w   = W'(fc_r) + W'(sc_r) - W'(2);
  assign iend_w   = (W'(k_r) < W'(fc_r) - W'(1)) ? W'(k_r) : W'(fc_r) - W'(1);
  assign is_last  = (W'(i_r) == iend_w);
  assign kn_w     = W'(k_r) + W'(1);
  assign istart_n = (kn_w >= W'(sc_r)) ? idx_t'(kn_w - W'(sc_r) + W'(1)) : '0;
  assign raddr_b  = idx_t'(W'(k_r) - W'(i_r));

  assign issue.valid = (state_r == ST_MAC);
  assign issue.first = first_r;
  assign issue.last  = is_last;
  assign issue.k     = k_r;

  pm_opstore u_opstore (
    .clk     (clk),
    .we_a    (we_a),
    .we_b    (we_b),
    .waddr   (waddr),
    .wdata   (in_val),
    .raddr_a (i_r),
    .raddr_b (raddr_b),
    .rdata_a (rd_a),
    .rdata_b (rd_b)
  );

  pm_mac u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .issue (issue),
    .op_a  (rd_a),
    .op_b  (rd_b),
    .res   (res),
    .busy  (mac_busy)
  );

  // product memory: one coefficient per degree, written as each sum completes
  always_ff @(posedge clk) begin
    if (res.valid) begin
      prod_mem[res.k] <= res.sum;
    end
    if (state_r == ST_RD) begin
      prod_rd_r <= prod_mem[e_r];
    end
  end

  assign out_free = ~out_valid_r | out_if.ready;

  always_comb begin
    state_nxt     = state_r;
    fc_nxt        = fc_r;
    sc_nxt        = sc_r;
    too_many_nxt  = too_many_r;
    k_nxt         = k_r;
    i_nxt         = i_r;
    first_nxt     = first_r;
    any_nz_nxt    = any_nz_r;
    top_nxt       = top_r;
    e_nxt         = e_r;
    out_load      = 1'b0;
    out_load_zero = 1'b0;

    if (res.valid && res.sum != '0) begin
      any_nz_nxt = 1'b1;
      top_nxt    = res.k;
    end

    unique case (state_r)
      ST_LOAD: begin
        if (in_acc) begin
          if (!in_if.mode) begin
            if (we_a) begin
              fc_nxt = fc_r + cnt_t'(1);
            end else begin
              too_many_nxt = 1'b1;
            end
          end else begin
            if (we_b) begin
              sc_nxt = sc_r + cnt_t'(1);
            end else begin
              too_many_nxt = 1'b1;
            end
            if (in_if.last) begin
              k_nxt      = '0;
              i_nxt      = '0;
              first_nxt  = 1'b1;
              any_nz_nxt = 1'b0;
              state_nxt  = (fc_r == '0) ? ST_ZERO : ST_MAC;
            end
          end
        end
      end
      ST_MAC: begin
        first_nxt = 1'b0;
        if (is_last) begin
          if (W'(k_r) == kmax_w) begin
            state_nxt = ST_DRAIN;
          end else begin
            k_nxt     = deg_t'(kn_w);
            i_nxt     = istart_n;
            first_nxt = 1'b1;
          end
        end else begin
          i_nxt = i_r + idx_t'(1);
        end
      end
      ST_DRAIN: begin
        if (!mac_busy) begin
          e_nxt     = '0;
          state_nxt = any_nz_r ? ST_RD : ST_ZERO;
        end
      end
      ST_RD: begin
        state_nxt = ST_LD;
      end
      ST_LD: begin
        if (out_free) begin
          out_load = 1'b1;
          if (e_r == top_r) begin
            state_nxt    = ST_LOAD;
            fc_nxt       = '0;
            sc_nxt       = '0;
            too_many_nxt = 1'b0;
          end else begin
            e_nxt     = e_r + deg_t'(1);
            state_nxt = ST_RD;
          end
        end
      end
      ST_ZERO: begin
        if (out_free) begin
          out_load_zero = 1'b1;
          state_nxt     = ST_LOAD;
          fc_nxt        = '0;
          sc_nxt        = '0;
          too_many_nxt  = 1'b0;
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_if.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (out_load || out_load_zero) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      fc_r        <= '0;
      sc_r        <= '0;
      too_many_r  <= 1'b0;
      out_valid_r <= 1'b0;
      first_r     <= 1'b0;
      any_nz_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fc_r        <= fc_nxt;
      sc_r        <= sc_nxt;
      too_many_r  <= too_many_nxt;
      out_valid_r <= out_valid_nxt;
      first_r     <= first_nxt;
      any_nz_r    <= any_nz_nxt;
    end
  end

  always_ff @(posedge clk) begin
    k_r   <= k_nxt;
    i_r   <= i_nxt;
    top_r <= top_nxt;
    e_r   <= e_nxt;
    if (out_load) begin
      out_coeff_r <= prod_rd_r;
      out_deg_r   <= e_r;
      out_last_r  <= (e_r == top_r);
      out_zero_r  <= 1'b0;
      out_ovf_r   <= too_many_r;
    end else if (out_load_zero) begin
      out_coeff_r <= '0;
      out_deg_r   <= '0;
      out_last_r  <= 1'b1;
      out_zero_r  <= 1'b1;
      out_ovf_r   <= too_many_r;
    end
  end

  assign out_if.valid      = out_valid_r;
  assign out_if.prod_coeff = OUT_COEFF_W'(signed'(out_coeff_r));
  assign out_if.degree     = OUT_DEG_W'(out_deg_r);
  assign out_if.last_res   = out_last_r;
  assign out_if.is_zero    = out_zero_r;
  assign out_if.overflow   = out_ovf_r;

endmodule
